FILE: hdl/block_bitmap_allocator_assert.svh
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define BBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("block_bitmap_allocator assertion failed");

// next-cycle implication, ignored while reset is asserted
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("block_bitmap_allocator assertion failed");

// next-cycle implication, also checked across reset
`define BBA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("block_bitmap_allocator assertion failed");

`endif

FILE: hdl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_W         = 64;
    localparam int WORD_LOG       = 6;
    localparam int IDX_W          = 12;
    localparam int CFG_W          = 13;
    localparam int POP_W          = WORD_LOG + 1;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 13'd4096;

    localparam logic [1:0] OP_QUERY   = 2'd0;
    localparam logic [1:0] OP_OCCUPY  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_TAIL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
    } t_scan_ctl;

endpackage

`default_nettype wire

FILE: hdl/bba_map_ram.sv
`default_nettype none

module bba_map_ram #(
    parameter int DEPTH  = bba_pkg::MAX_BLOCKS_DEF / bba_pkg::WORD_W,
    parameter int ADDR_W = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output logic [bba_pkg::WORD_W-1:0]     o_rd_data,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic [bba_pkg::WORD_W-1:0] i_wr_data
);

    logic [bba_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bba_scan.sv
`default_nettype none

module bba_scan #(
    parameter int CW = bba_pkg::CFG_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bba_pkg::t_scan_ctl         i_ctl,
    input  wire logic [CW-1:0]              i_len,
    input  wire logic [CW-6:0]              i_word_idx,
    input  wire logic [bba_pkg::WORD_W-1:0] i_word,
    output logic [CW-1:0]                   o_count,
    output logic                            o_found,
    output logic [CW-1:0]                   o_first
);

    localparam int NW_W = CW - 5;

    logic [bba_pkg::WORD_W-1:0]    free_bits;
    logic [bba_pkg::WORD_LOG-1:0]  lim;
    logic                          partial;
    logic [bba_pkg::POP_W-1:0]     pop;
    logic [bba_pkg::WORD_LOG-1:0]  pos;
    logic [NW_W+bba_pkg::WORD_LOG-1:0] abs_pos;

    logic [CW-1:0] r_count;
    logic          r_found;
    logic [CW-1:0] r_first;

    // only the last word may hold blocks beyond the usable length
    assign lim     = i_len[bba_pkg::WORD_LOG-1:0];
    assign partial = (i_word_idx == NW_W'(i_len[CW-1:bba_pkg::WORD_LOG]))
                     && (lim != '0);

    always_comb begin
        for (int b = 0; b < bba_pkg::WORD_W; b++) begin
            free_bits[b] = !i_word[b]
                           && (!partial || (bba_pkg::WORD_LOG'(b) < lim));
        end
    end

    always_comb begin
        pop = '0;
        for (int b = 0; b < bba_pkg::WORD_W; b++) begin
            pop = pop + bba_pkg::POP_W'(free_bits[b]);
        end
    end

    always_comb begin
        pos = '0;
        for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                pos = bba_pkg::WORD_LOG'(b);
            end
        end
    end

    assign abs_pos = {i_word_idx, pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_first <= '0;
        end else if (i_ctl.load) begin
            r_count <= r_count + CW'(pop);
            if (!r_found && (free_bits != '0)) begin
                r_found <= 1'b1;
                r_first <= abs_pos[CW-1:0];
            end
        end
    end

    assign o_count = r_count;
    assign o_found = r_found;
    assign o_first = r_first;

endmodule

`default_nettype wire

FILE: hdl/block_bitmap_allocator.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------------
// input     | i_in_valid / o_in_stall    | i_operation, i_block_index
// output    | o_out_valid / i_out_stall  | o_first_free, o_none_free, o_free_count,
//           |                            | o_index_error
// config    | i_cfg_wr_en                | i_cfg_wr_data (block count)
//
// the result is registered after the accept passes S_MOD, S_SCAN over the ceil(usable / 64)
// map words, S_TAIL and S_OUT (S_MOD goes straight to S_OUT at zero usable length); a new
// transaction is taken only in S_IDLE, once S_OUT has loaded the result
// the map scan reads one 64-bit word of the map ram per cycle
// after reset a clearing pass writes every ram word, with o_in_stall held high
// a result waiting under i_out_stall holds the next item at its last step only
`default_nettype none

module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [bba_pkg::IDX_W-1:0]  i_block_index,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [bba_pkg::IDX_W-1:0]       o_first_free,
    output logic                            o_none_free,
    output logic [bba_pkg::CFG_W-1:0]       o_free_count,
    output logic                            o_index_error,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bba_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    localparam int LEN_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CW     = (LEN_W > bba_pkg::CFG_W) ? LEN_W : bba_pkg::CFG_W;
    localparam int NW_W   = CW - 5;
    localparam int DEPTH  = (MAX_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WL     = bba_pkg::WORD_LOG;

    localparam logic [CW-1:0]   MAX_LEN   = CW'(MAX_BLOCKS);
    localparam logic [NW_W-1:0] LAST_WORD = NW_W'(DEPTH - 1);

    bba_pkg::t_state r_state, n_state;

    logic [bba_pkg::CFG_W-1:0] r_block_count;
    logic [CW-1:0]             r_len;
    logic [1:0]                r_op;
    logic [CW-1:0]             r_idx;
    logic                      r_err;
    logic [NW_W-1:0]           r_ptr, n_ptr;
    logic [NW_W-1:0]           r_dptr;
    logic                      r_dv;

    logic                      r_out_valid;
    logic [bba_pkg::IDX_W-1:0] r_first_free;
    logic                      r_none_free;
    logic [bba_pkg::CFG_W-1:0] r_free_count;
    logic                      r_index_error;

    logic [CW-1:0]             bc_ext;
    logic [CW-1:0]             cur_len;
    logic [CW-1:0]             in_idx;
    logic                      in_write_op;
    logic                      in_err;
    logic [NW_W-1:0]           num_words;
    logic                      accept;
    logic                      load_out;

    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [bba_pkg::WORD_W-1:0] rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [bba_pkg::WORD_W-1:0] wr_data;

    bba_pkg::t_scan_ctl scan_ctl;
    logic [CW-1:0]      scan_count;
    logic               scan_found;
    logic [CW-1:0]      scan_first;

    // usable length: block count limited to the map size, rounded down to a multiple of 8
    assign bc_ext  = CW'(r_block_count);
    assign cur_len = ((bc_ext > MAX_LEN) ? MAX_LEN : bc_ext) & ~CW'(7);

    assign in_idx      = CW'(i_block_index);
    assign in_write_op = (i_operation == bba_pkg::OP_OCCUPY)
                         || (i_operation == bba_pkg::OP_RELEASE);
    assign in_err      = in_write_op && (in_idx >= cur_len);

    assign num_words = NW_W'(r_len[CW-1:WL]) + NW_W'(r_len[WL-1:0] != '0);

    assign accept   = i_in_valid && !o_in_stall;
    assign load_out = (r_state == bba_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                if (r_ptr == LAST_WORD) n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bba_pkg::S_MOD;
            end
            bba_pkg::S_MOD: begin
                n_state = (num_words == '0) ? bba_pkg::S_OUT : bba_pkg::S_SCAN;
            end
            bba_pkg::S_SCAN: begin
                if (r_ptr == num_words - NW_W'(1)) n_state = bba_pkg::S_TAIL;
            end
            bba_pkg::S_TAIL: begin
                n_state = bba_pkg::S_OUT;
            end
            bba_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) n_state = bba_pkg::S_IDLE;
            end
            default: begin
                n_state = bba_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        rd_en          = 1'b0;
        rd_addr        = r_ptr[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = r_ptr[ADDR_W-1:0];
        wr_data        = '0;
        scan_ctl.clear = 1'b0;
        scan_ctl.load  = r_dv;
        n_ptr          = r_ptr;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_ptr = r_ptr + NW_W'(1);
            end
            bba_pkg::S_IDLE: begin
                o_in_stall     = 1'b0;
                rd_en          = i_in_valid;
                rd_addr        = in_idx[ADDR_W+WL-1:WL];
                scan_ctl.clear = i_in_valid;
            end
            bba_pkg::S_MOD: begin
                // read-modify-write of the addressed word (occupy or release, index in range) before the scan starts
                wr_en   = ((r_op == bba_pkg::OP_OCCUPY) || (r_op == bba_pkg::OP_RELEASE))
                          && !r_err;
                wr_addr = r_idx[ADDR_W+WL-1:WL];
                wr_data = rd_data;
                wr_data[r_idx[WL-1:0]] = (r_op == bba_pkg::OP_OCCUPY);
                n_ptr   = '0;
            end
            bba_pkg::S_SCAN: begin
                rd_en = 1'b1;
                n_ptr = r_ptr + NW_W'(1);
            end
            bba_pkg::S_TAIL: begin
                n_ptr = r_ptr;
            end
            bba_pkg::S_OUT: begin
                n_ptr = r_ptr;
            end
            default: begin
                n_ptr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bba_pkg::S_CLEAR;
            r_ptr         <= '0;
            r_dv          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_block_count <= bba_pkg::BLOCK_COUNT_RST;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_dv    <= (r_state == bba_pkg::S_SCAN);
            if (i_cfg_wr_en) begin
                r_block_count <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len <= cur_len;
            r_op  <= i_operation;
            r_idx <= in_idx;
            r_err <= in_err;
        end
        if (r_state == bba_pkg::S_SCAN) begin
            r_dptr <= r_ptr;
        end
        if (load_out) begin
            r_first_free  <= scan_first[bba_pkg::IDX_W-1:0];
            r_none_free   <= !scan_found;
            r_free_count  <= scan_count[bba_pkg::CFG_W-1:0];
            r_index_error <= r_err;
        end
    end

    bba_map_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    bba_scan #(
        .CW (CW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_len      (r_len),
        .i_word_idx (r_dptr),
        .i_word     (rd_data),
        .o_count    (scan_count),
        .o_found    (scan_found),
        .o_first    (scan_first)
    );

    assign o_out_valid   = r_out_valid;
    assign o_first_free  = r_first_free;
    assign o_none_free   = r_none_free;
    assign o_free_count  = r_free_count;
    assign o_index_error = r_index_error;

endmodule

`default_nettype wire

FILE: hdl/bba_checker.sv
`default_nettype none

`include "block_bitmap_allocator_assert.svh"

module bba_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [bba_pkg::IDX_W-1:0] o_first_free,
    input wire logic                      o_none_free,
    input wire logic [bba_pkg::CFG_W-1:0] o_free_count,
    input wire logic                      o_index_error
);

    // a full map reports index zero and no free blocks
    `BBA_ASSERT_NOW(a_full_map_result, i_clk, i_rst_n, o_out_valid && o_none_free, (o_first_free == '0) && (o_free_count == '0))

    // a map with a free block never reports a zero free count
    `BBA_ASSERT_NOW(a_free_count_nonzero, i_clk, i_rst_n, o_out_valid && !o_none_free, o_free_count != '0)

    // an accepted transaction keeps the input side busy in the next cycle
    `BBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // reset starts the clearing pass with nothing at the output
    `BBA_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, o_in_stall && !o_out_valid)

    // a stalled result holds
    `BBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_first_free) && $stable(o_none_free) && $stable(o_free_count) && $stable(o_index_error))

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_first_free  (o_first_free),
    .o_none_free   (o_none_free),
    .o_free_count  (o_free_count),
    .o_index_error (o_index_error)
);

`default_nettype wire

FILE: sim/block_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
    import bba_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int N_DIR = 31;
    localparam int N_PHASE = 10;
    localparam int HOLD_PHASE = 3;
    localparam int PAUSE_PHASE = 5;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [IDX_W-1:0] first_free;
        logic             none_free;
        logic [CFG_W-1:0] free_count;
        logic             index_error;
    } t_alloc_res;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] cfg_val;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic             typed;
        t_alloc_res       want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_ITEM, 13'd0,    OP_QUERY,   12'd0,    1'b1, '{12'd0, 1'b0, 13'd4096, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd0,    1'b1, '{12'd1, 1'b0, 13'd4095, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd4095, 1'b1, '{12'd1, 1'b0, 13'd4094, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_RELEASE, 12'd4095, 1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_SPARE,   12'd4095, 1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_RELEASE, 12'd1,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_QUERY,   12'd4095, 1'b0, '0},
        '{ROW_CFG,  13'd8191, OP_QUERY,   12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd4095, 1'b0, '0},
        '{ROW_CFG,  13'd16,   OP_QUERY,   12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_QUERY,   12'd0,    1'b1, '{12'd1, 1'b0, 13'd15, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd16,   1'b1, '{12'd1, 1'b0, 13'd15, 1'b1}},
        '{ROW_ITEM, 13'd0,    OP_RELEASE, 12'd4095, 1'b1, '{12'd1, 1'b0, 13'd15, 1'b1}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd15,   1'b0, '0},
        '{ROW_CFG,  13'd7,    OP_QUERY,   12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_QUERY,   12'd0,    1'b1, '{12'd0, 1'b1, 13'd0, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd0,    1'b1, '{12'd0, 1'b1, 13'd0, 1'b1}},
        '{ROW_ITEM, 13'd0,    OP_RELEASE, 12'd0,    1'b1, '{12'd0, 1'b1, 13'd0, 1'b1}},
        '{ROW_CFG,  13'd0,    OP_QUERY,   12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd4095, 1'b1, '{12'd0, 1'b1, 13'd0, 1'b1}},
        '{ROW_CFG,  13'd8,    OP_QUERY,   12'd0,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_QUERY,   12'd0,    1'b1, '{12'd1, 1'b0, 13'd7, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd1,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd2,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd3,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd4,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd5,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd6,    1'b0, '0},
        '{ROW_ITEM, 13'd0,    OP_OCCUPY,  12'd7,    1'b1, '{12'd0, 1'b1, 13'd0, 1'b0}},
        '{ROW_ITEM, 13'd0,    OP_RELEASE, 12'd3,    1'b0, '0}
    };

    localparam int PH_CFG   [N_PHASE] = '{4096, 24, 8191, 64, 0, 65, 4095, 8, 100, 31};
    localparam int PH_TX    [N_PHASE] = '{0,    85, 0,    22, 0,  85, 22,   0, 22,  85};
    localparam int PH_RX    [N_PHASE] = '{0,    0,  85,   22, 85, 0,  22,   85, 22, 0};
    localparam int PH_ITEMS [N_PHASE] = '{40,   80, 40,   80, 30, 80, 40,   80, 70,  60};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       operation = OP_QUERY;
    logic [IDX_W-1:0] block_index = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [IDX_W-1:0] first_free;
    logic             none_free;
    logic [CFG_W-1:0] free_count;
    logic             index_error;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    bit               occ_map [MAX_BLOCKS_DEF];
    logic [CFG_W-1:0] blk_cnt_model = BLOCK_COUNT_RST;
    t_alloc_res       alloc_expect_q [$];
    int               mismatch_cnt = 0;
    int               quiet_cycles = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    bit               hold_off_req = 1'b0;

    always #6 clk = ~clk;

    block_bitmap_allocator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_block_index (block_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_first_free  (first_free),
        .o_none_free   (none_free),
        .o_free_count  (free_count),
        .o_index_error (index_error),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    function automatic int usable_len(input logic [CFG_W-1:0] cnt);
        int n;
        n = cnt;
        if (n > MAX_BLOCKS_DEF) begin
            n = MAX_BLOCKS_DEF;
        end
        return n & ~7;
    endfunction

    function automatic t_alloc_res alloc_predict(input logic [1:0] op,
                                                 input logic [IDX_W-1:0] idx);
        t_alloc_res res;
        int ulen;
        int nfree;
        bit found;
        ulen = usable_len(blk_cnt_model);
        res = '0;
        nfree = 0;
        found = 1'b0;
        if (op == OP_OCCUPY || op == OP_RELEASE) begin
            if (int'(idx) < ulen) begin
                occ_map[idx] = (op == OP_OCCUPY);
            end else begin
                res.index_error = 1'b1;
            end
        end
        for (int i = 0; i < ulen; i++) begin
            if (!occ_map[i]) begin
                if (!found) begin
                    res.first_free = IDX_W'(i);
                    found = 1'b1;
                end
                nfree++;
            end
        end
        res.none_free = !found;
        res.free_count = CFG_W'(nfree);
        return res;
    endfunction

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (alloc_expect_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] val);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        blk_cnt_model = val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                             input logic typed, input t_alloc_res want);
        t_alloc_res predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        block_index <= idx;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        predicted = alloc_predict(op, idx);
        alloc_expect_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // receiver side, with one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_alloc_res got;
        t_alloc_res want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            got = '{first_free, none_free, free_count, index_error};
            if (alloc_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected transaction: ff=%0d nf=%0b fc=%0d ie=%0b",
                             got.first_free, got.none_free, got.free_count,
                             got.index_error);
                end
            end else begin
                want = alloc_expect_q.pop_front();
                if (got.first_free !== want.first_free || got.none_free !== want.none_free
                        || got.free_count !== want.free_count
                        || got.index_error !== want.index_error) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result mismatch: exp ff=%0d nf=%0b fc=%0d ie=%0b, got ff=%0d nf=%0b fc=%0d ie=%0b",
                                 want.first_free, want.none_free, want.free_count,
                                 want.index_error, got.first_free, got.none_free,
                                 got.free_count, got.index_error);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_dir_row row;
        int ulen;
        int r;
        int p;
        int k;
        logic [1:0] op;
        logic [IDX_W-1:0] idx;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            row = DIR_ROWS[k];
            if (row.kind == ROW_CFG) begin
                write_cfg(row.cfg_val);
            end else begin
                push_item(row.op, row.idx, row.typed, row.want);
            end
        end

        for (p = 0; p < N_PHASE; p++) begin
            write_cfg(CFG_W'(PH_CFG[p]));
            tx_idle_pct = PH_TX[p];
            rx_stall_pct = PH_RX[p];
            if (p == HOLD_PHASE) begin
                hold_off_req = 1'b1;
            end
            ulen = usable_len(blk_cnt_model);
            for (k = 0; k < PH_ITEMS[p]; k++) begin
                if (p == PAUSE_PHASE && k == PH_ITEMS[p] / 2) begin
                    wait_drain();
                end
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    op = OP_OCCUPY;
                end else if (r < 80) begin
                    op = OP_RELEASE;
                end else if (r < 92) begin
                    op = OP_QUERY;
                end else begin
                    op = OP_SPARE;
                end
                r = $urandom_range(0, 99);
                if (ulen == 0 || r < 15) begin
                    if (ulen >= MAX_BLOCKS_DEF) begin
                        idx = IDX_W'($urandom_range(0, MAX_BLOCKS_DEF - 1));
                    end else begin
                        idx = IDX_W'($urandom_range(ulen, MAX_BLOCKS_DEF - 1));
                    end
                end else if (r < 60) begin
                    idx = IDX_W'($urandom_range(0, (ulen < 128 ? ulen : 128) - 1));
                end else begin
                    idx = IDX_W'($urandom_range(0, ulen - 1));
                end
                push_item(op, idx, 1'b0, '0);
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && alloc_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_map_ram.sv
hdl/bba_scan.sv
hdl/block_bitmap_allocator.sv
hdl/bba_checker.sv
sim/block_bitmap_allocator_tb.sv
